FILE: sv/mbr_pkg.sv
// Shared types, constants and helpers for the MSB-first bit reader.
package mbr_pkg;

	localparam int WordBits   = 32;
	localparam int HoldBits   = 64;
	localparam int MaxGetBits = 32;

	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_PUSH  = 2'd1,
		CMD_GET   = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_UNDERFLOW = 2'd1,
		ST_FULL      = 2'd2
	} status_t;

	// One classified item as it waits between the front and the back.
	typedef struct packed {
		cmd_t        op;
		logic [31:0] word;
		logic [5:0]  count;
	} q_entry_t;

	// Queue occupancy as seen by the front and the back.
	typedef struct packed {
		logic full;
		logic valid;
	} q_stat_t;

	typedef struct packed {
		logic [31:0] value;
		status_t     status;
		logic [6:0]  held;
		logic [2:0]  offset;
	} result_t;

	function automatic logic [31:0] byte_reverse(input logic [31:0] w);
		byte_reverse = {w[7:0], w[15:8], w[23:16], w[31:24]};
	endfunction

endpackage

FILE: sv/mbr_front.sv
// Front end: accepts input transactions, applies byte swap and clamps the request size.
module mbr_front import mbr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,
	input  logic [1:0]  s_tuser,
	input  q_stat_t     q_stat,
	output logic        q_push,
	output q_entry_t    q_entry
);

	logic        swap_q;
	logic [31:0] word_in;
	logic [5:0]  count_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			swap_q <= 1'b1;
		end else if (cfg_we) begin
			swap_q <= cfg_wdata;
		end
	end

	assign word_in  = s_tdata[31:0];
	assign count_in = s_tdata[37:32];

	assign s_tready = !q_stat.full;
	assign q_push   = s_tvalid && s_tready;

	always_comb begin
		q_entry.op    = cmd_t'(s_tuser);
		q_entry.word  = swap_q ? byte_reverse(word_in) : word_in;
		q_entry.count = (count_in > 6'(MaxGetBits)) ? 6'(MaxGetBits) : count_in;
	end

endmodule

FILE: sv/mbr_queue.sv
// Two-entry queue between the front end and the execution back end.
module mbr_queue import mbr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  q_entry_t wr_entry,
	input  logic     pop,
	output q_entry_t rd_entry,
	output q_stat_t  stat
);

	q_entry_t   mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign rd_entry   = mem_q[rd_ptr_q];
	assign stat.full  = count_q[1];
	assign stat.valid = (count_q != 2'd0);

endmodule

FILE: sv/mbr_back.sv
// Back end: 64-bit bit buffer; one command per cycle into the output register when not stalled.
module mbr_back import mbr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  q_stat_t  q_stat,
	input  q_entry_t q_entry,
	output logic     q_pop,
	output logic     out_valid,
	input  logic     out_ready,
	output result_t  out_res
);

	logic [63:0] hold_q;
	logic [6:0]  held_q;
	logic [63:0] hold_d;
	logic [6:0]  held_d;
	logic        out_valid_q;
	result_t     out_res_q;
	result_t     res_d;

	assign q_pop = q_stat.valid && (!out_valid_q || out_ready);

	always_comb begin
		hold_d       = hold_q;
		held_d       = held_q;
		res_d.value  = 32'd0;
		res_d.status = ST_OK;
		case (q_entry.op)
			CMD_CLEAR: begin
				hold_d = 64'd0;
				held_d = 7'd0;
			end
			CMD_PUSH: begin
				if (held_q > 7'(HoldBits - WordBits)) begin
					res_d.status = ST_FULL;
				end else begin
					// New word lands directly below the bits already held.
					hold_d = hold_q | (64'(q_entry.word[WordBits-1:0])
						<< (7'(HoldBits - WordBits) - held_q));
					held_d = held_q + 7'(WordBits);
				end
			end
			CMD_GET: begin
				if (7'(q_entry.count) > held_q) begin
					res_d.status = ST_UNDERFLOW;
				end else begin
					// A zero-bit request shifts by the full width and yields zero.
					res_d.value = hold_q[63:32] >> (6'(MaxGetBits) - q_entry.count);
					hold_d      = hold_q << q_entry.count;
					held_d      = held_q - 7'(q_entry.count);
				end
			end
			default: begin
			end
		endcase
		res_d.held   = held_d;
		res_d.offset = held_d[2:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q      <= 64'd0;
			held_q      <= 7'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				hold_q      <= hold_d;
				held_q      <= held_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			out_res_q <= res_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;

endmodule

FILE: sv/msb_first_bit_reader.sv
// Flow: accepted transactions are written into a two-entry queue that decouples the back
// end from the input; each result is registered in the output register. Throughput: one
// transaction and one command per cycle while the output is not stalled (64-bit shifts).
// Reset: arst_n clears the holding register and bit count, empties the queue and output,
// and sets swap_q to 1.
module msb_first_bit_reader import mbr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // word_data[31:0], bit_count[37:32], zero fill
	input  logic [1:0]  s_tuser,   // command[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // field_value[31:0], held_count[38:32], byte_offset[41:39]
	output logic [1:0]  m_tuser    // status[1:0]
);

	q_stat_t  q_stat;
	q_entry_t push_entry;
	q_entry_t head_entry;
	logic     q_push;
	logic     q_pop;
	result_t  res;

	mbr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_stat   (q_stat),
		.q_push   (q_push),
		.q_entry  (push_entry)
	);

	mbr_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_entry(push_entry),
		.pop     (q_pop),
		.rd_entry(head_entry),
		.stat    (q_stat)
	);

	mbr_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_stat   (q_stat),
		.q_entry  (head_entry),
		.q_pop    (q_pop),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_res  (res)
	);

	assign m_tdata = {6'd0, res.offset, res.held, res.value};
	assign m_tuser = res.status;

`ifndef SYNTHESIS
	a_offset_tracks_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (res.offset == res.held[2:0]))
		else $error("byte_offset does not match held_count");

	a_count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (res.held <= 7'(HoldBits)))
		else $error("held_count exceeds holder size");

	a_error_zero_value: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (res.status != ST_OK)) |-> (res.value == 32'd0))
		else $error("nonzero field_value on error status");

	a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(!q_stat.valid && !q_push) |=> !q_pop)
		else $error("queue popped while empty");
`endif

endmodule

FILE: sim/msb_first_bit_reader_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the MSB-first bit reader: stream driver, result monitor, predictor.
module msb_first_bit_reader_test;
	import mbr_pkg::*;

	localparam int StallLimit  = 2000;
	localparam int HoldOffLen  = 80;
	localparam int DrainCycles = 6;

	typedef struct {
		cmd_t        op;
		logic [31:0] word;
		logic [5:0]  count;
	} read_req_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;   // word_data[31:0], bit_count[37:32], zero fill
	logic [1:0]  s_tuser;   // command[1:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;   // field_value[31:0], held_count[38:32], byte_offset[41:39]
	logic [1:0]  m_tuser;   // status[1:0]

	msb_first_bit_reader dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	// Predictor state: the holder, its bit count and the byte swap setting.
	logic [63:0] hold_reg = '0;
	logic [6:0]  held_now = '0;
	logic        swap_now = 1'b1;

	read_req_t req_queue[$];
	result_t   expected_fields[$];
	read_req_t next_req;
	result_t   want;

	bit in_taken      = 1'b0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_asked    = 0;
	int hold_served   = 0;
	int hold_left     = 0;
	int stalled_cycles = 0;
	int error_count   = 0;
	int items_in      = 0;
	int results_out   = 0;
	int underflow_seen = 0;
	int full_seen     = 0;
	int cfg_writes    = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Works out the result of one command and advances the predicted holder.
	function automatic result_t read_step(cmd_t op, logic [31:0] word, logic [5:0] count);
		logic [31:0] w;
		logic [6:0]  n;
		result_t     r;
		r = '0;
		r.status = ST_OK;
		case (op)
			CMD_CLEAR: begin
				hold_reg = '0;
				held_now = '0;
			end
			CMD_PUSH: begin
				if (held_now > HoldBits - WordBits) begin
					r.status = ST_FULL;
				end else begin
					w = word;
					if (swap_now)
						w = {<<8{word}};
					hold_reg = hold_reg | ({32'b0, w} << (HoldBits - WordBits - held_now));
					held_now = held_now + 7'(WordBits);
				end
			end
			CMD_GET: begin
				n = (count > MaxGetBits) ? 7'(MaxGetBits) : {1'b0, count};
				if (n > held_now) begin
					r.status = ST_UNDERFLOW;
				end else if (n != 0) begin
					r.value = 32'(hold_reg >> (HoldBits - n));
					hold_reg = hold_reg << n;
					held_now = held_now - n;
				end
			end
			default: ;
		endcase
		r.held = held_now;
		r.offset = held_now[2:0];
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint exp_val);
		$display("MISMATCH %s: got %0h, expected %0h (result %0d)", what, got, exp_val,
			results_out);
		error_count++;
	endtask

	task automatic add_req(cmd_t op, logic [31:0] word, logic [5:0] count);
		read_req_t r;
		r.op = op;
		r.word = word;
		r.count = count;
		req_queue.push_back(r);
	endtask

	// Mostly pushes and gets with sizes spread over the legal range, a few clears,
	// unused commands and oversized requests.
	task automatic add_random_req();
		int          pick;
		cmd_t        op;
		logic [5:0]  c;
		pick = $urandom_range(99);
		if (pick < 4)
			op = CMD_CLEAR;
		else if (pick < 8)
			op = CMD_NOP;
		else if (pick < 40)
			op = CMD_PUSH;
		else
			op = CMD_GET;
		case ($urandom_range(9))
			0: c = 6'd0;
			1: c = 6'd32;
			2: c = 6'($urandom_range(63, 33));
			default: c = 6'($urandom_range(31, 1));
		endcase
		add_req(op, $urandom, c);
	endtask

	// Returns once every queued item has been sent and every result has come back.
	task automatic drain();
		while (req_queue.size() != 0 || s_tvalid || expected_fields.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(negedge clk);
	endtask

	task automatic write_swap(logic v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		cfg_writes++;
	endtask

	task automatic run_phase(int n_items, int send_pct, int stall_pct);
		send_idle_pct = send_pct;
		recv_stall_pct = stall_pct;
		repeat (n_items) add_random_req();
		drain();
	endtask

	// Driver: offers the next pending item once the current one is taken.
	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || in_taken)) begin
			in_taken = 1'b0;
			if (req_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				next_req = req_queue.pop_front();
				s_tvalid <= 1'b1;
				s_tuser <= next_req.op;
				s_tdata <= {2'b00, next_req.count, next_req.word};
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, plus a long hold-off whenever one is asked for.
	always @(negedge clk) begin
		if (hold_left != 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (hold_served != hold_asked) begin
			hold_served++;
			hold_left = HoldOffLen;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Monitor: predicts on each input transaction, checks each output transaction.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we)
				swap_now = cfg_wdata;
			if (s_tvalid && s_tready) begin
				expected_fields.push_back(read_step(cmd_t'(s_tuser), s_tdata[31:0],
					s_tdata[37:32]));
				in_taken = 1'b1;
				items_in++;
			end
			if (m_tvalid && m_tready) begin
				if (expected_fields.size() == 0) begin
					report_mismatch("result with nothing pending", m_tdata[31:0], 0);
				end else begin
					want = expected_fields.pop_front();
					if (m_tdata[31:0] != want.value)
						report_mismatch("field_value", m_tdata[31:0], want.value);
					if (m_tuser != want.status)
						report_mismatch("status", m_tuser, want.status);
					if (m_tdata[38:32] != want.held)
						report_mismatch("held_count", m_tdata[38:32], want.held);
					if (m_tdata[41:39] != want.offset)
						report_mismatch("byte_offset", m_tdata[41:39], want.offset);
				end
				if (m_tuser == ST_UNDERFLOW)
					underflow_seen++;
				if (m_tuser == ST_FULL)
					full_seen++;
				results_out++;
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				stalled_cycles = 0;
			end else begin
				stalled_cycles++;
				if (stalled_cycles >= StallLimit) begin
					$display("Timeout: no transaction for %0d cycles", StallLimit);
					$display("Verification failed");
					$finish;
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = CMD_NOP;
		m_tready = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part, byte swap at its reset value.
		add_req(CMD_NOP, 32'hFFFF_FFFF, 6'd63);
		add_req(CMD_GET, 32'h0, 6'd0);
		add_req(CMD_GET, 32'h0, 6'd1);
		add_req(CMD_PUSH, 32'h0123_4567, 6'd0);
		add_req(CMD_PUSH, 32'h89AB_CDEF, 6'd0);
		add_req(CMD_PUSH, 32'hDEAD_BEEF, 6'd0);
		add_req(CMD_GET, 32'h0, 6'd63);
		add_req(CMD_GET, 32'h0, 6'd32);
		add_req(CMD_GET, 32'h0, 6'd1);
		add_req(CMD_GET, 32'h0, 6'd31);
		add_req(CMD_GET, 32'h0, 6'd5);
		add_req(CMD_PUSH, 32'hFFFF_FFFF, 6'd0);
		add_req(CMD_GET, 32'h0, 6'd3);
		add_req(CMD_NOP, 32'h0, 6'd0);
		add_req(CMD_CLEAR, 32'h0, 6'd0);
		add_req(CMD_GET, 32'h0, 6'd1);
		add_req(CMD_PUSH, 32'h0000_0000, 6'd0);
		add_req(CMD_PUSH, 32'hA5A5_A5A5, 6'd0);
		add_req(CMD_GET, 32'h0, 6'd17);
		add_req(CMD_PUSH, 32'h1234_5678, 6'd0);
		add_req(CMD_GET, 32'h0, 6'd33);
		add_req(CMD_CLEAR, 32'hFFFF_FFFF, 6'd63);
		drain();

		write_swap(1'b0);
		run_phase(130, 0, 0);
		write_swap(1'b1);
		run_phase(130, 57, 0);
		write_swap(1'b0);
		run_phase(130, 0, 57);

		// Receiver holds off while the sender keeps offering, so the input backs up.
		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (60) add_random_req();
		hold_asked++;
		drain();

		write_swap(1'b1);
		run_phase(130, 31, 31);
		write_swap(1'b0);
		run_phase(130, 31, 31);

		repeat (DrainCycles) @(posedge clk);
		$display("Covered %0d items in six phases with byte swap on and off (%0d writes).",
			items_in, cfg_writes);
		$display("Checked %0d results: %0d underflows, %0d dropped words, %0d mismatches.",
			results_out, underflow_seen, full_seen, error_count);
		if (error_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

FILE: filelist.f
sv/mbr_pkg.sv
sv/mbr_front.sv
sv/mbr_queue.sv
sv/mbr_back.sv
sv/msb_first_bit_reader.sv
sim/msb_first_bit_reader_test.sv
